// ----- rtl/mcr_pkg.sv -----
// Types and constants shared by the midpoint circle rasterizer modules.
// No dependencies.
package mcr_pkg;

  localparam int unsigned FieldBits = 16;
  localparam int unsigned DecBits   = 20;
  localparam int unsigned QueueDepth = 2;

  // Decision term constants of the midpoint recurrence.
  localparam logic [DecBits-1:0] DecInit = 20'd3;
  localparam logic [DecBits-1:0] DecKeep = 20'd6;
  localparam logic [DecBits-1:0] DecDiag = 20'd10;

  typedef enum logic [0:0] {
    OpStart   = 1'b0,
    OpAdvance = 1'b1
  } opcode_e;

  // One octant step handed from front to back: eight points follow from it.
  typedef struct packed {
    logic [FieldBits-1:0] cx;
    logic [FieldBits-1:0] cy;
    logic [FieldBits-1:0] x;
    logic [FieldBits-1:0] y;
    logic [FieldBits-1:0] colour;
    logic                 done;
  } job_t;

endpackage

// ----- rtl/mcr_cmd_if.sv -----
// Command channel of the circle rasterizer: start and advance items.
// Depends on mcr_pkg.
interface mcr_cmd_if
  import mcr_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic [FieldBits-1:0] centre_x;
  logic [FieldBits-1:0] centre_y;
  logic [FieldBits-1:0] radius;
  logic [FieldBits-1:0] pen_colour;

  modport source (output valid, opcode, centre_x, centre_y, radius, pen_colour,
                  input ready);
  modport sink   (input valid, opcode, centre_x, centre_y, radius, pen_colour,
                  output ready);
endinterface

// ----- rtl/mcr_pix_if.sv -----
// Pixel channel of the circle rasterizer: one point per transfer.
// Depends on mcr_pkg.
interface mcr_pix_if
  import mcr_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [FieldBits-1:0] point_x;
  logic [FieldBits-1:0] point_y;
  logic [FieldBits-1:0] pixel_colour;
  logic                 last_point;

  modport source (output valid, point_x, point_y, pixel_colour, last_point,
                  input ready);
  modport sink   (input valid, point_x, point_y, pixel_colour, last_point,
                  output ready);
endinterface

// ----- rtl/mcr_front.sv -----
// Front end: takes commands, holds circle state, runs the midpoint update
// and pushes one step record per live advance. Depends on mcr_pkg, mcr_cmd_if.
module mcr_front
  import mcr_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mcr_cmd_if.sink     cmd_i,
  output job_t        job_o,
  output logic        job_valid_o,
  input  logic        job_ready_i
);

  logic [COORD_BITS-1:0] x_q, x_d, y_q, y_d;
  logic [COORD_BITS-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [FieldBits-1:0]  col_q, col_d;
  logic [DecBits-1:0]    dec_q, dec_d;
  logic                  active_q, active_d;

  logic                  accept;
  logic                  is_start;
  logic [COORD_BITS-1:0] r_in;
  logic [DecBits-1:0]    x_w, y_w, dec_next;
  logic                  dec_neg;
  logic [COORD_BITS:0]   x_inc;
  logic                  done;

  // Ready while the queue has room; starts and idle advances need none
  // but sharing one condition keeps the handshake simple.
  assign cmd_i.ready = job_ready_i;
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign is_start    = (opcode_e'(cmd_i.opcode) == OpStart);
  assign r_in        = cmd_i.radius[COORD_BITS-1:0];

  assign x_w     = DecBits'(x_q);
  assign y_w     = DecBits'(y_q);
  assign dec_neg = dec_q[DecBits-1];
  assign x_inc   = {1'b0, x_q} + (COORD_BITS+1)'(1);

  always_comb begin
    if (dec_neg) begin
      dec_next = dec_q + (x_w << 2) + DecKeep;
    end else begin
      dec_next = dec_q + ((x_w - y_w) << 2) + DecDiag;
    end
  end

  // x+1 > y (keep) or x+1 > y-1 (diagonal), without going negative
  assign done = dec_neg ? (x_q >= y_q) : (x_inc >= {1'b0, y_q});

  assign job_valid_o = accept && !is_start && active_q;

  always_comb begin
    job_o        = '0;
    job_o.cx     = FieldBits'(cx_q);
    job_o.cy     = FieldBits'(cy_q);
    job_o.x      = FieldBits'(x_q);
    job_o.y      = FieldBits'(y_q);
    job_o.colour = col_q;
    job_o.done   = done;
  end

  always_comb begin
    x_d      = x_q;
    y_d      = y_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    col_d    = col_q;
    dec_d    = dec_q;
    active_d = active_q;
    if (accept && is_start) begin
      cx_d     = cmd_i.centre_x[COORD_BITS-1:0];
      cy_d     = cmd_i.centre_y[COORD_BITS-1:0];
      col_d    = cmd_i.pen_colour;
      x_d      = '0;
      y_d      = r_in;
      dec_d    = DecInit - (DecBits'(r_in) << 1);
      active_d = 1'b1;
    end else if (job_valid_o) begin
      x_d   = x_inc[COORD_BITS-1:0];
      y_d   = dec_neg ? y_q : (y_q - COORD_BITS'(1));
      dec_d = dec_next;
      if (done) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q      <= '0;
      y_q      <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      col_q    <= '0;
      dec_q    <= '0;
      active_q <= 1'b0;
    end else begin
      x_q      <= x_d;
      y_q      <= y_d;
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      col_q    <= col_d;
      dec_q    <= dec_d;
      active_q <= active_d;
    end
  end

endmodule

// ----- rtl/mcr_queue.sv -----
// Two-entry step queue between front and back.
// Depends on mcr_pkg.
module mcr_queue
  import mcr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  job_t in_job_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  output job_t out_job_o,
  output logic out_valid_o,
  input  logic out_ready_i
);

  localparam int unsigned PtrBits = $clog2(QueueDepth);
  localparam int unsigned CntBits = $clog2(QueueDepth + 1);

  job_t               mem_q [QueueDepth];
  logic [PtrBits-1:0] wr_q, rd_q;
  logic [CntBits-1:0] cnt_q;
  logic               push, pop;

  assign in_ready_o  = (cnt_q != CntBits'(QueueDepth));
  assign out_valid_o = (cnt_q != '0);
  assign out_job_o   = mem_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrBits'(QueueDepth - 1)) ? '0 : wr_q + PtrBits'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == PtrBits'(QueueDepth - 1)) ? '0 : rd_q + PtrBits'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntBits'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntBits'(1);
      end
    end
  end

endmodule

// ----- rtl/mcr_back.sv -----
// Back end: expands one step record into its eight mirrored points, one
// per cycle unless pix_o stalls, through an output register. Depends on mcr_pkg, mcr_pix_if.
module mcr_back
  import mcr_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  job_t      job_i,
  input  logic      job_valid_i,
  output logic      job_ready_o,
  mcr_pix_if.source pix_o
);

  localparam logic [FieldBits-1:0] CoordMask =
    FieldBits'((32'd1 << COORD_BITS) - 32'd1);

  job_t                 cur_q;
  logic                 cur_valid_q;
  logic [2:0]           idx_q;
  logic                 out_valid_q;
  logic [FieldBits-1:0] px_q, py_q, col_q;
  logic                 last_q;

  logic                 emit;
  logic                 final_pt;
  logic [FieldBits-1:0] off_a, off_b, px, py;

  assign emit        = cur_valid_q && (!out_valid_q || pix_o.ready);
  assign final_pt    = (idx_q == 3'd7);
  assign job_ready_o = !cur_valid_q || (emit && final_pt);

  // idx[2] swaps x and y, idx[0] negates the column term, idx[1] the row term
  assign off_a = idx_q[2] ? cur_q.y : cur_q.x;
  assign off_b = idx_q[2] ? cur_q.x : cur_q.y;
  assign px    = (idx_q[0] ? (cur_q.cx - off_a) : (cur_q.cx + off_a)) & CoordMask;
  assign py    = (idx_q[1] ? (cur_q.cy - off_b) : (cur_q.cy + off_b)) & CoordMask;

  always_ff @(posedge clk_i) begin
    if (job_valid_i && job_ready_o) begin
      cur_q <= job_i;
    end
    if (emit) begin
      px_q   <= px;
      py_q   <= py;
      col_q  <= cur_q.colour;
      last_q <= final_pt && cur_q.done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (job_ready_o) begin
        cur_valid_q <= job_valid_i;
      end
      if (emit) begin
        idx_q <= idx_q + 3'd1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (pix_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign pix_o.valid        = out_valid_q;
  assign pix_o.point_x      = px_q;
  assign pix_o.point_y      = py_q;
  assign pix_o.pixel_colour = col_q;
  assign pix_o.last_point   = last_q;

  a_stall_holds_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q && !emit |=> cur_valid_q && $stable(idx_q))
    else $error("step index moved while stalled");

  a_last_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && final_pt |=> pix_o.valid && (pix_o.last_point == $past(cur_q.done)))
    else $error("last flag does not follow step record");

  a_no_early_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !final_pt |=> !pix_o.last_point)
    else $error("last flag on a point other than the eighth");

  a_idx_zero_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i && job_ready_o |=> idx_q == 3'd0)
    else $error("new step does not start at its first point");

endmodule

// ----- rtl/midpoint_circle_rasterizer.sv -----
// Midpoint circle rasterizer top level: front end, step queue, point back end.
// Depends on mcr_pkg, mcr_cmd_if, mcr_pix_if, mcr_front, mcr_queue, mcr_back.
//
//   channel  dir  handshake          payload
//   cmd_i    in   valid / ready      opcode, centre_x, centre_y, radius, pen_colour
//   pix_o    out  valid / ready      point_x, point_y, pixel_colour, last_point
//
// Commands: a start loads the circle and gives nothing; an advance on a live
//   circle gives eight pixel transfers, one per cycle while pix_o is not
//   stalled, through the single output register of the back end.
// The front end updates the decision term in the cycle of the transfer and
//   queues the step (two entries), so commands keep flowing while points drain.
// Stalls: cmd_i.ready drops only when the step queue is full; pix_o stalls
//   hold the output register and the step in progress.
// Reset: asynchronous, active low; clears all control state and the circle
//   registers. No clearing pass.
module midpoint_circle_rasterizer
  import mcr_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mcr_cmd_if.sink   cmd_i,
  mcr_pix_if.source pix_o
);

  job_t front_job, back_job;
  logic front_valid, front_ready;
  logic back_valid, back_ready;

  // Circle state and midpoint recurrence; one step record per live advance.
  mcr_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .job_o       (front_job),
    .job_valid_o (front_valid),
    .job_ready_i (front_ready)
  );

  // Decouples the two halves so either may stall.
  mcr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_job_i    (front_job),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .out_job_o   (back_job),
    .out_valid_o (back_valid),
    .out_ready_i (back_ready)
  );

  // Eight mirrored points per step: four with x and y as given, then four swapped.
  mcr_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (back_job),
    .job_valid_i (back_valid),
    .job_ready_o (back_ready),
    .pix_o       (pix_o)
  );

endmodule
